// ===== hdl/plist_pkg.sv =====
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants for the positional list block.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = 7;
    localparam int OP_W     = 2;
    localparam int POS_W    = 9;
    localparam int MAG_W    = POS_W - 1;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = (CNT_W > MAG_W) ? CNT_W : MAG_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NEG    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd3;

    localparam logic signed [DATA_W-1:0] NOT_FOUND = -32'sd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_FETCH,
        S_FETCH_WAIT,
        S_REM_RD,
        S_REM_WR,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic signed [POS_W-1:0]  position;
        logic signed [DATA_W-1:0] value_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entry_count;
    } rslt_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

endpackage

// ===== hdl/plist_req_if.sv =====
// ----------------------------------------------------------------------------
// plist_req_if
// Request channel carrying one list operation with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plist_req_if import plist_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          operation;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value_in;

    modport source (
        output valid,
        output operation,
        output position,
        output value_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  position,
        input  value_in,
        output ready
    );

endinterface

// ===== hdl/plist_rsp_if.sv =====
// ----------------------------------------------------------------------------
// plist_rsp_if
// Response channel carrying one list result with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface plist_rsp_if import plist_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] value_out;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         entry_count;

    modport source (
        output valid,
        output value_out,
        output status,
        output entry_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  value_out,
        input  status,
        input  entry_count,
        output ready
    );

endinterface

// ===== hdl/positional_list_insert_remove_peek_top.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_remove_peek_top
// Ordered list of signed 32-bit values with insert, remove and peek by index.
// ----------------------------------------------------------------------------
// Each request inserts a value at a list position, removes the value at a
// position or peeks at it, and produces exactly one result giving the value
// found, a status and the number of entries left. The list lives in a memory
// with one write port and one registered read port, and every entry that has
// to move is read in a read state and written back in a write state. Requests
// are taken one at a time; the result sits in an output register, so the next
// request is accepted while it waits.
module positional_list_insert_remove_peek_top import plist_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    plist_req_if.sink   req,
    plist_rsp_if.source rsp
);

    core_stat_t stat;
    rslt_t      rslt;
    req_t       req_data;
    logic       start;
    logic       out_free;

    logic  rsp_valid_reg, rsp_valid_next;
    rslt_t rsp_data_reg, rsp_data_next;

    assign req_data.operation = req.operation;
    assign req_data.position  = req.position;
    assign req_data.value_in  = req.value_in;

    assign req.ready = stat.idle;
    assign start     = req.valid && stat.idle;
    assign out_free  = !rsp_valid_reg || rsp.ready;

    plist_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req_data),
        .out_free (out_free),
        .stat     (stat),
        .rslt     (rslt)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_data_next  = rsp_data_reg;
        if (stat.done)
        begin
            rsp_valid_next = 1'b1;
            rsp_data_next  = rslt;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.value_out   = rsp_data_reg.value_out;
    assign rsp.status      = rsp_data_reg.status;
    assign rsp.entry_count = rsp_data_reg.entry_count;

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

endmodule

// ===== hdl/plist_core.sv =====
// ----------------------------------------------------------------------------
// plist_core
// Entry memory and the sequencer that moves entries one at a time.
// ----------------------------------------------------------------------------
module plist_core import plist_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  req_t       req,
    input  logic       out_free,
    output core_stat_t stat,
    output rslt_t      rslt
);

    logic signed [DATA_W-1:0] mem [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    seq_state_t state_reg, state_next;
    logic [OP_W-1:0]          op_reg, op_next;
    logic [ADDR_W-1:0]        pos_reg, pos_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         occ_reg, occ_next;
    logic signed [DATA_W-1:0] res_val_reg, res_val_next;
    logic [STAT_W-1:0]        res_stat_reg, res_stat_next;

    logic                     mem_we;
    logic [ADDR_W-1:0]        wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic [ADDR_W-1:0]        rd_addr;

    logic              in_neg;
    logic              in_beyond;
    logic              list_full;
    logic [CMP_W-1:0]  pos_cmp;
    logic [CMP_W-1:0]  occ_cmp;
    logic [ADDR_W-1:0] ins_target;
    logic              idx_at_pos;
    logic              rem_last;

    assign pos_cmp    = CMP_W'(req.position[MAG_W-1:0]);
    assign occ_cmp    = CMP_W'(occ_reg);
    assign in_neg     = req.position[POS_W-1];
    assign in_beyond  = (pos_cmp >= occ_cmp);
    assign list_full  = (occ_reg == CNT_W'(CAPACITY));
    assign ins_target = in_beyond ? ADDR_W'(occ_reg) : ADDR_W'(req.position[MAG_W-1:0]);
    assign idx_at_pos = (idx_reg == pos_reg);
    assign rem_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) >= occ_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if ((req.operation == OP_INSERT) && !in_neg && !list_full)
                        state_next = S_INS_RD;
                    else if (((req.operation == OP_REMOVE) || (req.operation == OP_PEEK))
                             && !in_neg && !in_beyond)
                        state_next = S_FETCH;
                    else
                        state_next = S_DONE;
                end
            end
            S_INS_RD:
            begin
                if (idx_at_pos)
                    state_next = S_DONE;
                else
                    state_next = S_INS_WR;
            end
            S_INS_WR:     state_next = S_INS_RD;
            S_FETCH:      state_next = S_FETCH_WAIT;
            S_FETCH_WAIT:
            begin
                if (op_reg == OP_REMOVE)
                    state_next = S_REM_RD;
                else
                    state_next = S_DONE;
            end
            S_REM_RD:
            begin
                if (rem_last)
                    state_next = S_DONE;
                else
                    state_next = S_REM_WR;
            end
            S_REM_WR:     state_next = S_REM_RD;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op_next       = op_reg;
        pos_next      = pos_reg;
        idx_next      = idx_reg;
        val_next      = val_reg;
        occ_next      = occ_reg;
        res_val_next  = res_val_reg;
        res_stat_next = res_stat_reg;
        mem_we        = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = rd_data_reg;
        rd_addr       = idx_reg;
        stat.idle     = 1'b0;
        stat.done     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                stat.idle = 1'b1;
                if (start)
                begin
                    op_next       = req.operation;
                    val_next      = req.value_in;
                    res_stat_next = STAT_OK;
                    res_val_next  = '0;
                    unique case (req.operation) inside
                        OP_INSERT:
                        begin
                            pos_next = ins_target;
                            idx_next = ADDR_W'(occ_reg);
                            if (in_neg)
                                res_stat_next = STAT_NEG;
                            else if (list_full)
                                res_stat_next = STAT_FULL;
                        end
                        OP_REMOVE, OP_PEEK:
                        begin
                            pos_next     = ADDR_W'(req.position[MAG_W-1:0]);
                            res_val_next = NOT_FOUND;
                            if (in_neg)
                                res_stat_next = STAT_NEG;
                            else if (in_beyond)
                                res_stat_next = STAT_BEYOND;
                        end
                        default:
                        begin
                            res_stat_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                rd_addr = idx_reg - ADDR_W'(1);
                if (idx_at_pos)
                begin
                    mem_we   = 1'b1;
                    wr_addr  = pos_reg;
                    wr_data  = val_reg;
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            S_INS_WR:
            begin
                mem_we   = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_reg - ADDR_W'(1);
            end
            S_FETCH:
            begin
                rd_addr = pos_reg;
            end
            S_FETCH_WAIT:
            begin
                res_val_next = rd_data_reg;
                idx_next     = pos_reg;
            end
            S_REM_RD:
            begin
                rd_addr = idx_reg + ADDR_W'(1);
                if (rem_last)
                    occ_next = occ_reg - CNT_W'(1);
            end
            S_REM_WR:
            begin
                mem_we   = 1'b1;
                wr_addr  = idx_reg;
                wr_data  = rd_data_reg;
                idx_next = idx_reg + ADDR_W'(1);
            end
            S_DONE:
            begin
                stat.done = out_free;
            end
            default:
            begin
                stat.idle = 1'b0;
            end
        endcase
    end

    assign rslt.value_out   = res_val_reg;
    assign rslt.status      = res_stat_reg;
    assign rslt.entry_count = occ_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        val_reg      <= val_next;
        res_val_reg  <= res_val_next;
        res_stat_reg <= res_stat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

endmodule

// ===== verif/plist_outcome_checker.sv =====
// ----------------------------------------------------------------------------
// plist_outcome_checker
// Watches both channels of the positional list, keeps its own copy of the
// list, works out the outcome of every accepted request and compares each
// accepted result against the oldest outcome still owed.
// ----------------------------------------------------------------------------
module plist_outcome_checker import plist_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    plist_req_if        req,
    plist_rsp_if        rsp,
    output int          mismatches,
    output int          backlog,
    output int          requests_seen,
    output int          results_seen,
    output int          full_refusals,
    output int          emptied
);

    logic signed [DATA_W-1:0] shelf [CAPACITY];
    int                       fill;
    rslt_t                    outcome_fifo [$];

    assign backlog = outcome_fifo.size();

    task automatic apply_list_op(input req_t r, output rslt_t o);
        int p;
        int k;
        o.value_out   = '0;
        o.status      = STAT_OK;
        o.entry_count = '0;
        p             = int'(r.position[MAG_W-1:0]);
        case (r.operation) inside
            OP_INSERT:
            begin
                if (r.position[POS_W-1])
                begin
                    o.status = STAT_NEG;
                end
                else if (fill >= CAPACITY)
                begin
                    o.status = STAT_FULL;
                end
                else
                begin
                    if (p > fill)
                    begin
                        p = fill;
                    end
                    for (k = fill; k > p; k--)
                    begin
                        shelf[k] = shelf[k-1];
                    end
                    shelf[p] = r.value_in;
                    fill++;
                end
            end
            OP_REMOVE, OP_PEEK:
            begin
                if (r.position[POS_W-1])
                begin
                    o.value_out = NOT_FOUND;
                    o.status    = STAT_NEG;
                end
                else if (p >= fill)
                begin
                    o.value_out = NOT_FOUND;
                    o.status    = STAT_BEYOND;
                end
                else
                begin
                    o.value_out = shelf[p];
                    if (r.operation == OP_REMOVE)
                    begin
                        for (k = p; k + 1 < fill; k++)
                        begin
                            shelf[k] = shelf[k+1];
                        end
                        fill--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        o.entry_count = CNT_W'(fill);
    endtask

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        $display("mismatch on result %0d: %s is %h, should be %h",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        req_t  r;
        rslt_t o;
        rslt_t w;
        if (!rst_n)
        begin
            fill          = 0;
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
            full_refusals = 0;
            emptied       = 0;
            outcome_fifo.delete();
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                r.operation = req.operation;
                r.position  = req.position;
                r.value_in  = req.value_in;
                apply_list_op(r, o);
                if (o.status == STAT_FULL)
                begin
                    full_refusals++;
                end
                if (r.operation == OP_REMOVE && o.status == STAT_OK && fill == 0)
                begin
                    emptied++;
                end
                outcome_fifo.push_back(o);
                requests_seen++;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (outcome_fifo.size() == 0)
                begin
                    note_mismatch("result with no request owed", rsp.value_out, '0);
                end
                else
                begin
                    w = outcome_fifo.pop_front();
                    if (rsp.value_out !== w.value_out)
                    begin
                        note_mismatch("value_out", rsp.value_out, w.value_out);
                    end
                    if (rsp.status !== w.status)
                    begin
                        note_mismatch("status", DATA_W'(rsp.status), DATA_W'(w.status));
                    end
                    if (rsp.entry_count !== w.entry_count)
                    begin
                        note_mismatch("entry_count", DATA_W'(rsp.entry_count),
                                      DATA_W'(w.entry_count));
                    end
                end
                results_seen++;
            end
        end
    end

endmodule

// ===== verif/positional_list_insert_remove_peek_top_test.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_remove_peek_top_test
// Drives directed and random insert, remove and peek requests into the
// positional list with bursty requests and a stalling receiver, and gives the
// verdict from the mismatch count and backlog of the outcome checker.
// ----------------------------------------------------------------------------
module positional_list_insert_remove_peek_top_test;
    import plist_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int PHASE_LEN    = 150;
    localparam int IDLE_LIMIT   = 4000;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    plist_req_if req_ch ();
    plist_rsp_if rsp_ch ();

    int mismatches;
    int backlog;
    int requests_seen;
    int results_seen;
    int full_refusals;
    int emptied;

    int sent;
    int burst_left;

    positional_list_insert_remove_peek_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    plist_outcome_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .backlog       (backlog),
        .requests_seen (requests_seen),
        .results_seen  (results_seen),
        .full_refusals (full_refusals),
        .emptied       (emptied)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic offer(input logic [OP_W-1:0] op, input logic signed [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] val);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
            else
            begin
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 15);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.position  <= pos;
        req_ch.value_in  <= val;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        sent++;
    endtask

    function automatic logic signed [POS_W-1:0] pick_position(input int reach);
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            return POS_W'($urandom_range(0, reach));
        end
        else if (r < 88)
        begin
            return POS_W'($urandom_range(0, 255));
        end
        return {1'b1, 8'($urandom)};
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'sh0;
            1:       return -32'sd1;
            2:       return 32'sh7fffffff;
            3:       return 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        int next_hold_at;
        int holds_done;
        mode         = 0;
        mode_left    = 0;
        hold_left    = 0;
        next_hold_at = 300;
        holds_done   = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (holds_done < 2 && sent >= next_hold_at)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                next_hold_at = next_hold_at + 900;
                holds_done++;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
            if (idle >= IDLE_LIMIT)
            begin
                $display("no request or result moved for %0d cycles", IDLE_LIMIT);
                $display("positional_list_insert_remove_peek_top_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int r;
        int reach;
        logic [OP_W-1:0] op;
        sent             = 0;
        burst_left       = 0;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.operation <= OP_INSERT;
        req_ch.position  <= '0;
        req_ch.value_in  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer(OP_PEEK,   9'sd0,   32'sd0);
        offer(OP_REMOVE, 9'sd0,   32'sd0);
        offer(OP_INSERT, 9'sd0,   32'sh7fffffff);
        offer(OP_INSERT, 9'sd255, 32'sh80000000);
        offer(OP_INSERT, 9'sd1,   32'sd0);
        offer(OP_INSERT, -9'sd1,  32'sd5);
        offer(OP_INSERT, -9'sd256, -32'sd1);
        offer(OP_PEEK,   9'sd0,   $urandom);
        offer(OP_PEEK,   9'sd1,   $urandom);
        offer(OP_PEEK,   9'sd2,   $urandom);
        offer(OP_PEEK,   9'sd3,   $urandom);
        offer(OP_PEEK,   9'sd255, $urandom);
        offer(OP_PEEK,   -9'sd1,  $urandom);
        offer(OP_REMOVE, -9'sd256, $urandom);
        offer(OP_UNUSED, -9'sd1,  $urandom);
        offer(OP_UNUSED, 9'sd255, $urandom);
        offer(OP_REMOVE, 9'sd1,   32'sd0);
        offer(OP_REMOVE, 9'sd1,   32'sd0);
        offer(OP_REMOVE, 9'sd5,   32'sd0);
        offer(OP_INSERT, 9'sd0,   -32'sd1);
        offer(OP_INSERT, 9'sd0,   32'sd1);
        offer(OP_REMOVE, 9'sd0,   32'sd0);
        offer(OP_REMOVE, 9'sd0,   32'sd0);
        offer(OP_REMOVE, 9'sd0,   32'sd0);
        offer(OP_REMOVE, 9'sd0,   32'sd0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            r = $urandom_range(0, 99);
            if (((i / PHASE_LEN) % 2) == 0)
            begin
                reach = 66;
                op = (r < 68) ? OP_INSERT : (r < 84) ? OP_REMOVE :
                     (r < 98) ? OP_PEEK : OP_UNUSED;
            end
            else
            begin
                reach = 24;
                op = (r < 15) ? OP_INSERT : (r < 78) ? OP_REMOVE :
                     (r < 97) ? OP_PEEK : OP_UNUSED;
            end
            offer(op, pick_position(reach), pick_value());
        end
        req_ch.valid <= 1'b0;
        @(posedge clk);

        while (backlog != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);

        $display("%0d requests sent, %0d results checked against the predicted list",
                 requests_seen, results_seen);
        $display("%0d inserts refused on a full list, %0d removes left the list empty",
                 full_refusals, emptied);
        if (mismatches == 0 && backlog == 0)
        begin
            $display("positional_list_insert_remove_peek_top_test: done, clean");
        end
        else
        begin
            $display("positional_list_insert_remove_peek_top_test: done, errors");
        end
        $finish;
    end

endmodule

// ===== positional_list_insert_remove_peek_top.f =====
hdl/plist_pkg.sv
hdl/plist_req_if.sv
hdl/plist_rsp_if.sv
hdl/plist_core.sv
hdl/positional_list_insert_remove_peek_top.sv
verif/plist_outcome_checker.sv
verif/positional_list_insert_remove_peek_top_test.sv
